// ===== rtl/ptb_pkg.sv =====
// Shared definitions for the palindromic tree builder: defaults, field widths,
// root node numbers, the sequencer state type and the child table command.
// No dependencies.
package ptb_pkg;

   // Default configuration of the builder.
   localparam int MAX_LEN_DEF  = 4096;
   localparam int ALPHABET_DEF = 26;

   // Fixed field widths of the channels.
   localparam int LETTER_W = 5;
   localparam int SUFFIX_W = 13;

   // Node numbers of the two roots and of the first real node.
   localparam int ODD_ROOT    = 1;
   localparam int EVEN_ROOT   = 2;
   localparam int FIRST_CHILD = 3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK_LEN,
      ST_WALK_CHK,
      ST_CHILD_VFY1,
      ST_CHILD_CHK1,
      ST_CREATE,
      ST_CHILD_VFY2,
      ST_CHILD_CHK2,
      ST_FINISH
   } ptb_state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } child_cmd_type;

endpackage

// ===== rtl/ptb_if.sv =====
// Valid/ready channel interfaces of the palindromic tree builder.
// Depends on ptb_pkg for the field widths.
interface ptb_req_if;
   logic                          valid;
   logic                          ready;
   logic [ptb_pkg::LETTER_W-1:0]  letter;
   logic                          last_letter;

   modport source (output valid, letter, last_letter, input ready);
   modport sink   (input valid, letter, last_letter, output ready);
endinterface

interface ptb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ptb_pkg::SUFFIX_W-1:0]  suffix_pal_len;
   logic                          overflow;
   logic                          string_end;

   modport source (output valid, suffix_pal_len, overflow, string_end, input ready);
   modport sink   (input valid, suffix_pal_len, overflow, string_end, output ready);
endinterface

// ===== rtl/ptb_child_table.sv =====
// Child table of the palindromic tree: one node number per (node, letter) pair.
// Synchronous memory with a registered read. Depends on ptb_pkg.
module ptb_child_table #(
   parameter  int MAX_LEN  = ptb_pkg::MAX_LEN_DEF,
   parameter  int ALPHABET = ptb_pkg::ALPHABET_DEF,
   localparam int NODE_W   = $clog2(MAX_LEN + 3)
) (
   input  logic                          clock,
   input  ptb_pkg::child_cmd_type        cmd,
   input  logic [NODE_W-1:0]             node,
   input  logic [ptb_pkg::LETTER_W-1:0]  letter,
   input  logic [NODE_W-1:0]             wr_node,
   output logic [NODE_W-1:0]             rd_node
);

   localparam int CHILD_DEPTH = (MAX_LEN + 2) * ALPHABET;
   localparam int CHILD_AW    = $clog2(CHILD_DEPTH);

   logic [NODE_W-1:0]   child_mem [CHILD_DEPTH];
   logic [CHILD_AW-1:0] node_off;
   logic [CHILD_AW-1:0] addr;
   logic [NODE_W-1:0]   rd_q_ff;

   // Row of the node times the alphabet size, plus the letter column.
   assign node_off = CHILD_AW'(node - NODE_W'(1));
   assign addr     = node_off * CHILD_AW'(ALPHABET)
                     + CHILD_AW'(letter - ptb_pkg::LETTER_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         child_mem[addr] <= wr_node;
      end
      if (cmd.rd_en) begin
         rd_q_ff <= child_mem[addr];
      end
   end

   assign rd_node = rd_q_ff;

endmodule

// ===== rtl/palindromic_tree_builder_unit.sv =====
// Top level of the palindromic tree builder: sequencer, node/letter memory and
// response register. Depends on ptb_pkg, ptb_if (ptb_req_if, ptb_rsp_if) and
// ptb_child_table.
//
//   channel   direction  words carried                       handshake
//   req_ch    in         letter, last_letter                 valid/ready
//   rsp_ch    out        suffix_pal_len, overflow, string_end valid/ready
//
// One letter is handled at a time. A letter past capacity or out of range goes
// from the accept step straight to the final step. For a stored letter the
// accept step and the final step are states of their own; every node visited
// by a walk takes a length step, and a compare step as well when the letter
// before its palindrome is compared; a child lookup is followed by a check
// when the entry names a live node; creating a node is a step of its own,
// followed by further link steps unless its parent is the odd root; the walk
// is bound by the single read port of the node memory, which serves one node
// lookup and one letter lookup per link step.
// Reset: synchronous and active high; it restores the two roots, the node
// count and the position. Memories are not cleared, neither at reset nor at
// a string end: every entry is checked against the node count, the position
// and the stored parent of a node, so stale contents are never used.
// Stalls: a finished word waits in the response register; the next letter is
// accepted meanwhile, and only the final step waits for the register to free.
module palindromic_tree_builder_unit #(
   parameter int MAX_LEN  = ptb_pkg::MAX_LEN_DEF,
   parameter int ALPHABET = ptb_pkg::ALPHABET_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ptb_req_if.sink    req_ch,
   ptb_rsp_if.source  rsp_ch
);

   localparam int POS_W      = $clog2(MAX_LEN + 1);
   localparam int LEN_W      = POS_W;
   localparam int LW1        = LEN_W + 1;
   localparam int NODE_W     = $clog2(MAX_LEN + 3);
   localparam int NODE_DEPTH = MAX_LEN + 3;
   localparam int LETTER_W   = ptb_pkg::LETTER_W;

   localparam logic [NODE_W-1:0] ODD  = NODE_W'(ptb_pkg::ODD_ROOT);
   localparam logic [NODE_W-1:0] EVEN = NODE_W'(ptb_pkg::EVEN_ROOT);

   // One word of the node memory. The chr field is the letter store, indexed
   // by string position; the other fields describe the node of that number.
   typedef struct packed {
      logic [LETTER_W-1:0] chr;
      logic [LEN_W-1:0]    len;
      logic [NODE_W-1:0]   link;
      logic [NODE_W-1:0]   par;
      logic [LETTER_W-1:0] plet;
   } node_word_type;

   // Sequencer and string state.
   ptb_pkg::ptb_state_type state_ff, state_in;
   logic [LETTER_W-1:0] c_ff, c_in;
   logic                last_ff, last_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [NODE_W-1:0]   node_total_ff, node_total_in;
   logic [NODE_W-1:0]   cur_node_ff, cur_node_in;
   logic [NODE_W-1:0]   u_ff, u_in;
   logic [LEN_W-1:0]    u_len_ff, u_len_in;
   logic [NODE_W-1:0]   u_link_ff, u_link_in;
   logic [NODE_W-1:0]   k_ff, k_in;
   logic [NODE_W-1:0]   lk_ff, lk_in;
   logic                phase_ff, phase_in;
   logic [LEN_W-1:0]    len_out_ff, len_out_in;
   logic                ovf_ff, ovf_in;

   // Response register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ptb_pkg::SUFFIX_W-1:0] rsp_len_ff, rsp_len_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;
   logic                         rsp_end_ff, rsp_end_in;

   // Node memory ports.
   node_word_type       node_mem [NODE_DEPTH];
   node_word_type       nm_rd_q;
   logic                nm_rd_en;
   logic [NODE_W-1:0]   nm_rd_addr;
   logic                nm_wr_chr;
   logic                nm_wr_node;
   logic                nm_wr_link;
   logic [NODE_W-1:0]   nm_wr_addr;
   node_word_type       nm_wr_data;

   // Child table ports.
   ptb_pkg::child_cmd_type child_cmd;
   logic [NODE_W-1:0]      child_wr;
   logic [NODE_W-1:0]      child_rd;

   // Decode helpers.
   logic                req_fire;
   logic                slot_free;
   logic                letter_ok;
   logic [LEN_W-1:0]    eff_len;
   logic [NODE_W-1:0]   eff_link;
   logic                can_look;
   logic [POS_W-1:0]    look_idx;
   logic                kc_valid;
   logic                nd_match;
   logic                p_odd;
   logic [LEN_W-1:0]    new_len;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign letter_ok = (req_ch.letter != '0) && (int'(req_ch.letter) <= ALPHABET);

   // The even root is not in memory: length 0, link to the odd root.
   assign eff_len  = (u_ff == EVEN) ? '0 : nm_rd_q.len;
   assign eff_link = (u_ff == EVEN) ? ODD : nm_rd_q.link;

   // The letter before the palindrome exists only when len + 1 < pos.
   assign can_look = ({1'b0, eff_len} + LW1'(1)) < {1'b0, pos_ff};
   assign look_idx = pos_ff - eff_len - POS_W'(1);

   // A child entry counts only if it names a node of the current string whose
   // stored parent and letter agree; anything else is left over from before.
   assign kc_valid = (child_rd >= NODE_W'(ptb_pkg::FIRST_CHILD))
                     && (child_rd <= node_total_ff);
   assign nd_match = (nm_rd_q.par == u_ff) && (nm_rd_q.plet == c_ff);

   assign p_odd   = (u_ff == ODD);
   assign new_len = p_odd ? LEN_W'(1) : u_len_ff + LEN_W'(2);

   always_comb begin
      state_in      = state_ff;
      c_in          = c_ff;
      last_in       = last_ff;
      pos_in        = pos_ff;
      node_total_in = node_total_ff;
      cur_node_in   = cur_node_ff;
      u_in          = u_ff;
      u_len_in      = u_len_ff;
      u_link_in     = u_link_ff;
      k_in          = k_ff;
      lk_in         = lk_ff;
      phase_in      = phase_ff;
      len_out_in    = len_out_ff;
      ovf_in        = ovf_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_len_in    = rsp_len_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_end_in    = rsp_end_ff;

      nm_rd_en      = 1'b0;
      nm_rd_addr    = u_ff;
      nm_wr_chr     = 1'b0;
      nm_wr_node    = 1'b0;
      nm_wr_link    = 1'b0;
      nm_wr_addr    = k_ff;
      nm_wr_data    = '0;

      child_cmd     = '0;
      child_wr      = k_ff;

      unique case (state_ff)
         ptb_pkg::ST_IDLE: begin
            if (req_fire) begin
               c_in       = req_ch.letter;
               last_in    = req_ch.last_letter;
               len_out_in = '0;
               ovf_in     = 1'b0;
               if (int'(pos_ff) >= MAX_LEN) begin
                  ovf_in   = 1'b1;
                  state_in = ptb_pkg::ST_FINISH;
               end else if (letter_ok) begin
                  // Store the letter and start the first walk at the current node.
                  nm_wr_chr       = 1'b1;
                  nm_wr_addr      = NODE_W'(pos_ff) + NODE_W'(1);
                  nm_wr_data.chr  = req_ch.letter;
                  pos_in          = pos_ff + POS_W'(1);
                  u_in            = cur_node_ff;
                  phase_in        = 1'b0;
                  nm_rd_en        = 1'b1;
                  nm_rd_addr      = cur_node_ff;
                  state_in        = ptb_pkg::ST_WALK_LEN;
               end else begin
                  state_in = ptb_pkg::ST_FINISH;
               end
            end
         end

         ptb_pkg::ST_WALK_LEN: begin
            if (p_odd) begin
               // The odd root always extends: look up its child.
               child_cmd.rd_en = 1'b1;
               state_in = phase_ff ? ptb_pkg::ST_CHILD_VFY2 : ptb_pkg::ST_CHILD_VFY1;
            end else begin
               u_len_in  = eff_len;
               u_link_in = eff_link;
               if (can_look) begin
                  nm_rd_en   = 1'b1;
                  nm_rd_addr = NODE_W'(look_idx);
                  state_in   = ptb_pkg::ST_WALK_CHK;
               end else begin
                  u_in       = eff_link;
                  nm_rd_en   = 1'b1;
                  nm_rd_addr = eff_link;
               end
            end
         end

         ptb_pkg::ST_WALK_CHK: begin
            if (nm_rd_q.chr == c_ff) begin
               child_cmd.rd_en = 1'b1;
               state_in = phase_ff ? ptb_pkg::ST_CHILD_VFY2 : ptb_pkg::ST_CHILD_VFY1;
            end else begin
               u_in       = u_link_ff;
               nm_rd_en   = 1'b1;
               nm_rd_addr = u_link_ff;
               state_in   = ptb_pkg::ST_WALK_LEN;
            end
         end

         ptb_pkg::ST_CHILD_VFY1: begin
            if (kc_valid) begin
               k_in       = child_rd;
               nm_rd_en   = 1'b1;
               nm_rd_addr = child_rd;
               state_in   = ptb_pkg::ST_CHILD_CHK1;
            end else begin
               state_in = ptb_pkg::ST_CREATE;
            end
         end

         ptb_pkg::ST_CHILD_CHK1: begin
            if (nd_match) begin
               cur_node_in = k_ff;
               len_out_in  = nm_rd_q.len;
               state_in    = ptb_pkg::ST_FINISH;
            end else begin
               state_in = ptb_pkg::ST_CREATE;
            end
         end

         ptb_pkg::ST_CREATE: begin
            if (int'(node_total_ff) < MAX_LEN + 2) begin
               // New node: written in full now with the even root as its link,
               // so that its parent fields are current before the second walk.
               k_in            = node_total_ff + NODE_W'(1);
               node_total_in   = node_total_ff + NODE_W'(1);
               child_cmd.wr_en = 1'b1;
               child_wr        = node_total_ff + NODE_W'(1);
               nm_wr_node      = 1'b1;
               nm_wr_addr      = node_total_ff + NODE_W'(1);
               nm_wr_data.len  = new_len;
               nm_wr_data.link = EVEN;
               nm_wr_data.par  = u_ff;
               nm_wr_data.plet = c_ff;
               cur_node_in     = node_total_ff + NODE_W'(1);
               len_out_in      = new_len;
               if (p_odd) begin
                  state_in = ptb_pkg::ST_FINISH;
               end else begin
                  phase_in   = 1'b1;
                  u_in       = u_link_ff;
                  nm_rd_en   = 1'b1;
                  nm_rd_addr = u_link_ff;
                  state_in   = ptb_pkg::ST_WALK_LEN;
               end
            end else begin
               len_out_in = '0;
               state_in   = ptb_pkg::ST_FINISH;
            end
         end

         ptb_pkg::ST_CHILD_VFY2: begin
            if (kc_valid) begin
               lk_in      = child_rd;
               nm_rd_en   = 1'b1;
               nm_rd_addr = child_rd;
               state_in   = ptb_pkg::ST_CHILD_CHK2;
            end else begin
               state_in = ptb_pkg::ST_FINISH;
            end
         end

         ptb_pkg::ST_CHILD_CHK2: begin
            if (nd_match) begin
               nm_wr_link      = 1'b1;
               nm_wr_addr      = k_ff;
               nm_wr_data.link = lk_ff;
            end
            state_in = ptb_pkg::ST_FINISH;
         end

         ptb_pkg::ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = ptb_pkg::SUFFIX_W'(len_out_ff);
               rsp_ovf_in   = ovf_ff;
               rsp_end_in   = last_ff;
               if (last_ff) begin
                  // End of string: back to the two bare roots.
                  node_total_in = EVEN;
                  cur_node_in   = EVEN;
                  pos_in        = '0;
               end
               state_in = ptb_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ptb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ptb_pkg::ST_IDLE;
         pos_ff        <= '0;
         node_total_ff <= EVEN;
         cur_node_ff   <= EVEN;
         phase_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         node_total_ff <= node_total_in;
         cur_node_ff   <= cur_node_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff       <= c_in;
      last_ff    <= last_in;
      u_ff       <= u_in;
      u_len_ff   <= u_len_in;
      u_link_ff  <= u_link_in;
      k_ff       <= k_in;
      lk_ff      <= lk_in;
      len_out_ff <= len_out_in;
      ovf_ff     <= ovf_in;
      rsp_len_ff <= rsp_len_in;
      rsp_ovf_ff <= rsp_ovf_in;
      rsp_end_ff <= rsp_end_in;
   end

   // Node memory: field writes at one address, one registered read.
   always_ff @(posedge clock) begin
      if (nm_wr_chr) begin
         node_mem[nm_wr_addr].chr <= nm_wr_data.chr;
      end
      if (nm_wr_node) begin
         node_mem[nm_wr_addr].len  <= nm_wr_data.len;
         node_mem[nm_wr_addr].par  <= nm_wr_data.par;
         node_mem[nm_wr_addr].plet <= nm_wr_data.plet;
      end
      if (nm_wr_node || nm_wr_link) begin
         node_mem[nm_wr_addr].link <= nm_wr_data.link;
      end
      if (nm_rd_en) begin
         nm_rd_q <= node_mem[nm_rd_addr];
      end
   end

   ptb_child_table #(
      .MAX_LEN  (MAX_LEN),
      .ALPHABET (ALPHABET)
   ) u_child (
      .clock   (clock),
      .cmd     (child_cmd),
      .node    (u_ff),
      .letter  (c_ff),
      .wr_node (child_wr),
      .rd_node (child_rd)
   );

   assign req_ch.ready          = (state_ff == ptb_pkg::ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.suffix_pal_len = rsp_len_ff;
   assign rsp_ch.overflow       = rsp_ovf_ff;
   assign rsp_ch.string_end     = rsp_end_ff;

   // An accepted letter always starts work.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ptb_pkg::ST_IDLE)
      else $error("accepted letter left the sequencer idle");

   // The current node is always one that exists in this string.
   a_cur_in_tree: assert property (@(posedge clock) disable iff (reset)
      cur_node_ff <= node_total_ff && node_total_ff >= EVEN)
      else $error("current node beyond node count");

   // A response word is loaded only by the final step.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ptb_pkg::ST_FINISH)
      else $error("response raised outside the final step");

   // Each child table write adds exactly one node.
   a_child_wr_adds_node: assert property (@(posedge clock) disable iff (reset)
      child_cmd.wr_en |=> node_total_ff == $past(node_total_ff) + NODE_W'(1))
      else $error("child written without a new node");

endmodule
